FILE: rtl/tbd_pkg.sv
// Shared types and constants for the two-button timed debouncer.
package tbd_pkg;

    localparam int unsigned TIME_W = 32;

    typedef logic [TIME_W-1:0] t_time;

    localparam t_time DELAY_RESET = t_time'(20);

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_PRESS_DEB = 3'd1,
        PH_PRESS_OK  = 3'd2,
        PH_HELD      = 3'd3,
        PH_REL_DEB   = 3'd4,
        PH_REL_OK    = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        EDGE_NONE    = 2'd0,
        EDGE_PRESS   = 2'd1,
        EDGE_RELEASE = 2'd2
    } t_edge;

    typedef struct packed {
        t_edge edge_a;
        t_edge edge_b;
    } t_lane_edges;

endpackage

FILE: rtl/tbd_if.sv
// Valid/ready channel interfaces for samples, results and the delay register.
interface tbd_in_if;
    logic          valid;
    logic          ready;
    logic          button_a_down;
    logic          button_b_down;
    tbd_pkg::t_time sample_time;

    modport source (output valid, button_a_down, button_b_down, sample_time, input ready);
    modport sink   (input valid, button_a_down, button_b_down, sample_time, output ready);
endinterface

interface tbd_out_if;
    logic           valid;
    logic           ready;
    tbd_pkg::t_edge edge_a;
    tbd_pkg::t_edge edge_b;
    tbd_pkg::t_time event_time;

    modport source (output valid, edge_a, edge_b, event_time, input ready);
    modport sink   (input valid, edge_a, edge_b, event_time, output ready);
endinterface

interface tbd_cfg_if;
    logic           valid;
    logic           ready;
    tbd_pkg::t_time data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/tbd_lane.sv
// One button lane: phase machine, transition timestamp and edge detection.
module tbd_lane (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_down,
    input  tbd_pkg::t_time i_now,
    input  tbd_pkg::t_time i_delay,
    output tbd_pkg::t_edge o_edge
);
    import tbd_pkg::*;

    t_phase r_phase;
    t_phase n_phase;
    t_time  r_last;
    t_time  n_last;
    t_time  elapsed;
    logic   settled;

    assign elapsed = i_now - r_last;
    assign settled = (elapsed >= i_delay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_last  <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_last  = r_last;
        o_edge  = EDGE_NONE;
        unique case (r_phase)
            PH_PRESS_DEB: begin
                if (!i_down) begin
                    n_phase = PH_IDLE;
                    n_last  = i_now;
                end else if (settled) begin
                    n_phase = PH_PRESS_OK;
                    o_edge  = EDGE_PRESS;
                end
            end
            PH_PRESS_OK, PH_HELD: begin
                if (i_down) begin
                    n_phase = PH_HELD;
                end else begin
                    n_phase = PH_REL_DEB;
                    n_last  = i_now;
                end
            end
            PH_REL_DEB: begin
                if (i_down) begin
                    n_phase = PH_PRESS_DEB;
                    n_last  = i_now;
                end else if (settled) begin
                    n_phase = PH_REL_OK;
                    n_last  = i_now;
                    o_edge  = EDGE_RELEASE;
                end
            end
            PH_REL_OK: begin
                n_phase = i_down ? PH_PRESS_DEB : PH_IDLE;
            end
            default: begin
                n_last  = i_now;
                n_phase = i_down ? PH_PRESS_DEB : PH_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_press_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_edge == EDGE_PRESS) |=> (r_phase == PH_PRESS_OK))
        else $error("press edge did not land in PressConfirmed");

    a_release_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_edge == EDGE_RELEASE) |=>
            (r_phase == PH_REL_OK && r_last == $past(i_now)))
        else $error("release edge did not record phase and time");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_phase) && $stable(r_last)))
        else $error("lane state moved without a sample");
`endif

endmodule

FILE: rtl/tbd_merge.sv
// Merge stage: combine lane edges with the timestamp into the registered result word.
module tbd_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tbd_pkg::t_lane_edges i_edges,
    input  tbd_pkg::t_time       i_now,
    tbd_out_if.source            o_out
);
    import tbd_pkg::*;

    logic        r_valid;
    t_lane_edges r_edges;
    t_time       r_time;
    logic        accept;

    assign o_in_ready = !r_valid || o_out.ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_edges <= i_edges;
            r_time  <= i_now;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.edge_a     = r_edges.edge_a;
    assign o_out.edge_b     = r_edges.edge_b;
    assign o_out.event_time = r_time;

endmodule

FILE: rtl/two_button_timed_debouncer.sv
// Two-button timed debouncer: configuration register, two button lanes and merge stage.
//
// Usage:
//   i_in carries one sample word: raw levels of buttons A and B and a wrapping
//   32-bit millisecond timestamp. o_out returns one result word per sample:
//   an edge code for each button (none, press, release) and the sample time.
//   i_cfg writes the debounce delay in milliseconds; it is always ready. The
//   user writes it only while no sample is in flight; the block does not enforce this.
// Accept and result:
//   Results are valid in the cycle after acceptance; one sample per cycle is
//   accepted unless the output word waits. Lanes update phase and timestamp in
//   the accept cycle; the merge stage holds the single output register.
// Reset:
//   Both lanes return to Idle with a zero transition time, the delay returns
//   to 20 and the output register empties.
// Stall:
//   While the output word waits, i_in.ready drops and the lanes hold state;
//   ready follows o_out.ready in the same cycle once the word is taken.
module two_button_timed_debouncer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tbd_in_if.sink     i_in,
    tbd_out_if.source  o_out,
    tbd_cfg_if.sink    i_cfg
);
    import tbd_pkg::*;

    t_time       r_delay;
    logic        in_ready;
    logic        accept;
    t_edge       edge_a;
    t_edge       edge_b;
    t_lane_edges edges;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
        end else if (i_cfg.valid) begin
            r_delay <= i_cfg.data;
        end
    end

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    tbd_lane u_lane_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_down  (i_in.button_a_down),
        .i_now   (i_in.sample_time),
        .i_delay (r_delay),
        .o_edge  (edge_a)
    );

    tbd_lane u_lane_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_down  (i_in.button_b_down),
        .i_now   (i_in.sample_time),
        .i_delay (r_delay),
        .o_edge  (edge_b)
    );

    assign edges.edge_a = edge_a;
    assign edges.edge_b = edge_b;

    tbd_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_edges    (edges),
        .i_now      (i_in.sample_time),
        .o_out      (o_out)
    );

endmodule
